// ===== design/rbst_pkg.sv =====
package rbst_pkg;

   localparam int NUM_AXES   = 3;
   localparam int NUM_SLABS  = 2 * NUM_AXES;
   localparam int DIV_STAGES = 7;
   localparam int DIV_STEP   = 4;
   localparam int NUM_STAGES = 15;

   localparam logic [30:0] INF_MAG = 31'h7F800000;
   localparam logic [31:0] POS_INF = 32'h7F800000;
   localparam logic [31:0] QNAN    = 32'h7FC00000;
   localparam logic [31:0] POS_ZERO = 32'h00000000;

   typedef enum logic [2:0] {
      CSR_BOX_MIN_X,
      CSR_BOX_MIN_Y,
      CSR_BOX_MIN_Z,
      CSR_BOX_MAX_X,
      CSR_BOX_MAX_Y,
      CSR_BOX_MAX_Z
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_NUM,
      KIND_ZERO,
      KIND_INF,
      KIND_NAN
   } kind_type;

   typedef struct packed {
      logic              sgn;
      logic signed [9:0] ex;
      logic [23:0]       man;
      logic              zero;
      logic              inf;
      logic              nan;
   } unp_type;

   typedef struct packed {
      logic              sgn;
      logic signed [9:0] ex;
      logic [27:0]       mag;
      logic              inf;
      logic              nan;
   } sum_type;

   typedef struct packed {
      logic              sgn;
      logic signed [9:0] ex;
      logic [23:0]       dvs;
      logic [24:0]       rem;
      logic [27:0]       quo;
      kind_type          kind;
   } div_type;

   typedef struct packed {
      logic              sgn;
      logic signed [9:0] ex;
      logic [47:0]       prod;
      kind_type          kind;
   } prd_type;

   function automatic logic fp_is_nan(input logic [31:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
   endfunction

   // value = man * 2^(ex - 26), man[26] set or man zero
   function automatic logic [31:0] fp_round(input logic sgn, input logic signed [9:0] ex,
                                            input logic [26:0] man, input logic stk);
      logic signed [9:0] be;
      logic signed [9:0] sh;
      logic [26:0]       m2;
      logic [27:0]       mask;
      logic              s2;
      logic              up;
      logic [7:0]        ef;
      logic [30:0]       mag;
      be = ex + 10'sd127;
      sh = 10'sd1 - be;
      m2 = man;
      s2 = stk;
      ef = 8'd0;
      if (man == 27'd0) return {sgn, 31'd0};
      if (be >= 10'sd255) return {sgn, INF_MAG};
      if (be >= 10'sd1) begin
         ef = be[7:0];
      end else if (sh > 10'sd27) begin
         m2 = 27'd0;
         s2 = 1'b1;
      end else begin
         mask = (28'd1 << sh[4:0]) - 28'd1;
         s2   = stk | (|(man & mask[26:0]));
         m2   = man >> sh[4:0];
      end
      up  = m2[2] & (m2[3] | m2[1] | m2[0] | s2);
      mag = {ef, m2[25:3]} + {30'd0, up};
      return {sgn, mag};
   endfunction

   function automatic unp_type fp_unpack(input logic [31:0] x);
      unp_type     u;
      logic [23:0] f24;
      logic [4:0]  lz;
      u.sgn  = x[31];
      u.zero = (x[30:0] == 31'd0);
      u.inf  = (x[30:0] == INF_MAG);
      u.nan  = fp_is_nan(x);
      f24    = {1'b0, x[22:0]};
      lz     = 5'd0;
      if (x[30:23] != 8'd0) begin
         u.man = {1'b1, x[22:0]};
         u.ex  = $signed({2'b00, x[30:23]}) - 10'sd127;
      end else begin
         for (int i = 0; i < 24; i++) begin
            if (f24[i]) lz = 5'(23 - i);
         end
         u.man = f24 << lz;
         u.ex  = -10'sd126 - $signed({5'd0, lz});
      end
      return u;
   endfunction

   // a - b up to the add, with guard, round and sticky bits
   function automatic sum_type fp_sub_align(input logic [31:0] a, input logic [31:0] b);
      sum_type     r;
      logic [7:0]  ea;
      logic [7:0]  eb;
      logic [7:0]  el;
      logic [7:0]  es;
      logic [7:0]  diff;
      logic [23:0] sl;
      logic [23:0] ss;
      logic        sga;
      logic        sgb;
      logic        sgl;
      logic        sgs;
      logic [26:0] ml;
      logic [26:0] full;
      logic [26:0] ms;
      logic [26:0] mask;
      logic        stk;
      logic        a_inf;
      logic        b_inf;
      ea    = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      sga   = a[31];
      sgb   = ~b[31];
      a_inf = (a[30:0] == INF_MAG);
      b_inf = (b[30:0] == INF_MAG);
      if (a[30:0] >= b[30:0]) begin
         el = ea; es = eb; sgl = sga; sgs = sgb;
         sl = {(a[30:23] != 8'd0), a[22:0]};
         ss = {(b[30:23] != 8'd0), b[22:0]};
      end else begin
         el = eb; es = ea; sgl = sgb; sgs = sga;
         sl = {(b[30:23] != 8'd0), b[22:0]};
         ss = {(a[30:23] != 8'd0), a[22:0]};
      end
      diff = el - es;
      ml   = {sl, 3'b000};
      full = {ss, 3'b000};
      if (diff > 8'd26) begin
         ms  = 27'd0;
         stk = |ss;
      end else begin
         mask = (27'd1 << diff[4:0]) - 27'd1;
         stk  = |(full & mask);
         ms   = full >> diff[4:0];
      end
      ms[0] = ms[0] | stk;
      if (sgl != sgs) r.mag = {1'b0, ml} - {1'b0, ms};
      else            r.mag = {1'b0, ml} + {1'b0, ms};
      r.ex  = $signed({2'b00, el}) - 10'sd127;
      r.nan = fp_is_nan(a) | fp_is_nan(b) | (a_inf & b_inf & (sga != sgb));
      r.inf = a_inf | b_inf;
      r.sgn = r.inf ? (a_inf ? sga : sgb) : sgl;
      return r;
   endfunction

   function automatic logic [31:0] fp_sum_round(input sum_type s);
      logic [4:0]  lz;
      logic [26:0] man;
      lz = 5'd0;
      if (s.nan) return QNAN;
      if (s.inf) return {s.sgn, INF_MAG};
      if (s.mag == 28'd0) return POS_ZERO;
      if (s.mag[27]) return fp_round(s.sgn, s.ex + 10'sd1, s.mag[27:1], s.mag[0]);
      for (int i = 0; i < 27; i++) begin
         if (s.mag[i]) lz = 5'(26 - i);
      end
      man = s.mag[26:0] << lz;
      return fp_round(s.sgn, s.ex - $signed({5'd0, lz}), man, 1'b0);
   endfunction

   function automatic div_type fp_div_init(input unp_type u);
      div_type d;
      d.sgn = u.sgn;
      d.ex  = -u.ex;
      d.dvs = u.man;
      d.rem = 25'd1 << 23;
      d.quo = 28'd0;
      if (u.nan)       d.kind = KIND_NAN;
      else if (u.zero) d.kind = KIND_INF;
      else if (u.inf)  d.kind = KIND_ZERO;
      else             d.kind = KIND_NUM;
      return d;
   endfunction

   function automatic div_type fp_div_step(input div_type d);
      div_type n;
      n = d;
      for (int i = 0; i < DIV_STEP; i++) begin
         if (n.rem >= {1'b0, n.dvs}) begin
            n.rem = n.rem - {1'b0, n.dvs};
            n.quo = {n.quo[26:0], 1'b1};
         end else begin
            n.quo = {n.quo[26:0], 1'b0};
         end
         n.rem = {n.rem[23:0], 1'b0};
      end
      return n;
   endfunction

   function automatic logic [31:0] fp_div_round(input div_type d);
      logic [31:0] r;
      case (d.kind)
         KIND_NAN:  r = QNAN;
         KIND_INF:  r = {d.sgn, INF_MAG};
         KIND_ZERO: r = {d.sgn, 31'd0};
         default: begin
            if (d.quo[27]) r = fp_round(d.sgn, d.ex, d.quo[27:1], d.quo[0] | (d.rem != 25'd0));
            else           r = fp_round(d.sgn, d.ex - 10'sd1, d.quo[26:0], d.rem != 25'd0);
         end
      endcase
      return r;
   endfunction

   function automatic prd_type fp_mul_raw(input unp_type a, input unp_type b);
      prd_type p;
      p.sgn  = a.sgn ^ b.sgn;
      p.ex   = a.ex + b.ex;
      p.prod = a.man * b.man;
      if (a.nan | b.nan | (a.zero & b.inf) | (a.inf & b.zero)) p.kind = KIND_NAN;
      else if (a.inf | b.inf)                                  p.kind = KIND_INF;
      else if (a.zero | b.zero)                                p.kind = KIND_ZERO;
      else                                                     p.kind = KIND_NUM;
      return p;
   endfunction

   function automatic logic [31:0] fp_mul_round(input prd_type p);
      logic [31:0] r;
      case (p.kind)
         KIND_NAN:  r = QNAN;
         KIND_INF:  r = {p.sgn, INF_MAG};
         KIND_ZERO: r = {p.sgn, 31'd0};
         default: begin
            if (p.prod[47]) r = fp_round(p.sgn, p.ex + 10'sd1, p.prod[47:21], |p.prod[20:0]);
            else            r = fp_round(p.sgn, p.ex, p.prod[46:20], |p.prod[19:0]);
         end
      endcase
      return r;
   endfunction

   function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
      logic r;
      if (fp_is_nan(a) || fp_is_nan(b))                 r = 1'b0;
      else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) r = 1'b0;
      else if (a[31] && !b[31])                          r = 1'b1;
      else if (!a[31] && b[31])                          r = 1'b0;
      else if (!a[31])                                   r = a[30:0] < b[30:0];
      else                                               r = a[30:0] > b[30:0];
      return r;
   endfunction

   function automatic logic [31:0] fp_min(input logic [31:0] x, input logic [31:0] y);
      return fp_lt(y, x) ? y : x;
   endfunction

   function automatic logic [31:0] fp_max(input logic [31:0] x, input logic [31:0] y);
      return fp_lt(x, y) ? y : x;
   endfunction

endpackage

// ===== design/ray_box_slab_test.sv =====
// Throughput: one item per cycle while the output is not stalled; the 28-bit reciprocal divider is cut into
// seven stages of four quotient bits, so it never holds the pipeline.
// A stalled output freezes every stage together.
// Synchronous reset empties the pipeline and sets all box corners to +0.0.
module ray_box_slab_test
   import rbst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, hit_limit
   input  logic [223:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit, box_distance, zero pad
   output logic [39:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   logic                  adv;
   logic [NUM_STAGES:1]   vld_ff, vld_in;
   logic [31:0]           box_lo_ff [NUM_AXES];
   logic [31:0]           box_hi_ff [NUM_AXES];

   sum_type               sum_ff [NUM_SLABS];
   sum_type               sum_in [NUM_SLABS];
   div_type               div_ff [DIV_STAGES+1][NUM_AXES];
   div_type               div_in [DIV_STAGES+1][NUM_AXES];
   logic [31:0]           lim_ff [14];
   logic [31:0]           lim_in [14];
   logic [31:0]           dpk_ff [NUM_SLABS];
   logic [31:0]           dpk_in [NUM_SLABS];
   unp_type               du_ff  [8][NUM_SLABS];
   unp_type               du_in  [8][NUM_SLABS];
   logic [31:0]           rpk_ff [NUM_AXES];
   logic [31:0]           rpk_in [NUM_AXES];
   unp_type               ru_ff  [NUM_AXES];
   unp_type               ru_in  [NUM_AXES];
   prd_type               prd_ff [NUM_SLABS];
   prd_type               prd_in [NUM_SLABS];
   logic [31:0]           t_ff   [NUM_SLABS];
   logic [31:0]           t_in   [NUM_SLABS];
   logic [31:0]           lo_ff  [NUM_AXES];
   logic [31:0]           lo_in  [NUM_AXES];
   logic [31:0]           hi_ff  [NUM_AXES];
   logic [31:0]           hi_in  [NUM_AXES];
   logic [31:0]           mp_ff  [NUM_AXES];
   logic [31:0]           mp_in  [NUM_AXES];
   logic                  ovl_ff, ovl_in;
   logic [31:0]           dist_ff, dist_in;
   logic                  hit_ff, hit_in;
   logic [31:0]           bd_ff, bd_in;

   assign adv        = !vld_ff[NUM_STAGES] || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = vld_ff[NUM_STAGES];
   assign rsp_tdata  = {7'd0, bd_ff, hit_ff};
   assign vld_in     = {vld_ff[NUM_STAGES-1:1], req_tvalid};

   always_comb begin
      logic [31:0] org;
      logic [31:0] m;
      logic [31:0] nr;
      logic [31:0] fr;
      logic        fail;
      logic [31:0] d;
      int          b;
      // operands and divider setup
      for (int a = 0; a < NUM_AXES; a++) begin
         org = req_tdata[32*a +: 32];
         sum_in[2*a]   = fp_sub_align(box_lo_ff[a], org);
         sum_in[2*a+1] = fp_sub_align(box_hi_ff[a], org);
         div_in[0][a]  = fp_div_init(fp_unpack(req_tdata[32*(a+3) +: 32]));
      end
      lim_in[0] = req_tdata[223:192];
      for (int k = 1; k < 14; k++) lim_in[k] = lim_ff[k-1];
      for (int k = 1; k <= DIV_STAGES; k++) begin
         for (int a = 0; a < NUM_AXES; a++) div_in[k][a] = fp_div_step(div_ff[k-1][a]);
      end
      for (int s = 0; s < NUM_SLABS; s++) begin
         dpk_in[s]   = fp_sum_round(sum_ff[s]);
         du_in[0][s] = fp_unpack(dpk_ff[s]);
         for (int k = 1; k < 8; k++) du_in[k][s] = du_ff[k-1][s];
         prd_in[s]   = fp_mul_raw(du_ff[7][s], ru_ff[s/2]);
         t_in[s]     = fp_mul_round(prd_ff[s]);
      end
      for (int a = 0; a < NUM_AXES; a++) begin
         rpk_in[a] = fp_div_round(div_ff[DIV_STAGES][a]);
         ru_in[a]  = fp_unpack(rpk_ff[a]);
         lo_in[a]  = fp_min(t_ff[2*a], t_ff[2*a+1]);
         hi_in[a]  = fp_max(t_ff[2*a], t_ff[2*a+1]);
         m = POS_INF;
         if (fp_lt(POS_ZERO, t_ff[2*a])) m = t_ff[2*a];
         if (fp_lt(POS_ZERO, t_ff[2*a+1]) && fp_lt(t_ff[2*a+1], m)) m = t_ff[2*a+1];
         mp_in[a] = m;
      end
      // slab overlap per axis pair and nearest positive slab
      fail = 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
         b  = (a == NUM_AXES - 1) ? 0 : a + 1;
         nr = fp_max(lo_ff[a], lo_ff[b]);
         fr = fp_min(hi_ff[a], hi_ff[b]);
         if (fp_lt(fr, nr)) fail = 1'b1;
      end
      ovl_in = !fail;
      d = mp_ff[0];
      for (int a = 1; a < NUM_AXES; a++) d = fp_min(d, mp_ff[a]);
      dist_in = d;
      hit_in  = ovl_ff && !fp_lt(lim_ff[13], dist_ff);
      bd_in   = dist_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         for (int a = 0; a < NUM_AXES; a++) begin
            box_lo_ff[a] <= POS_ZERO;
            box_hi_ff[a] <= POS_ZERO;
         end
      end else begin
         if (adv) vld_ff <= vld_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_BOX_MIN_X: box_lo_ff[0] <= csr_data;
               CSR_BOX_MIN_Y: box_lo_ff[1] <= csr_data;
               CSR_BOX_MIN_Z: box_lo_ff[2] <= csr_data;
               CSR_BOX_MAX_X: box_hi_ff[0] <= csr_data;
               CSR_BOX_MAX_Y: box_hi_ff[1] <= csr_data;
               CSR_BOX_MAX_Z: box_hi_ff[2] <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff  <= sum_in;
         div_ff  <= div_in;
         lim_ff  <= lim_in;
         dpk_ff  <= dpk_in;
         du_ff   <= du_in;
         rpk_ff  <= rpk_in;
         ru_ff   <= ru_in;
         prd_ff  <= prd_in;
         t_ff    <= t_in;
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         mp_ff   <= mp_in;
         ovl_ff  <= ovl_in;
         dist_ff <= dist_in;
         hit_ff  <= hit_in;
         bd_ff   <= bd_in;
      end
   end

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NUM_STAGES] && !rsp_tready) |-> !req_tready)
      else $error("input taken while output stalled");

   a_item_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[1])
      else $error("accepted item lost at first stage");

   a_dist_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[32] == 1'b0) && (rsp_tdata[31:1] != 31'd0))
      else $error("box distance not positive");

   a_dist_not_nan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !((rsp_tdata[31:24] == 8'hFF) && (rsp_tdata[23:1] != 23'd0)))
      else $error("box distance is NaN");

endmodule

// ===== bench/ray_box_checker.sv =====
`timescale 1ns / 100ps

module ray_box_checker
   import rbst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [223:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [39:0]  rsp_tdata,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data,
   output int           mismatches,
   output int           pending
);

   typedef struct packed {
      logic        hit;
      logic [31:0] box_dist;
   } slab_result_type;

   logic [31:0]     corner_lo [3];
   logic [31:0]     corner_hi [3];
   slab_result_type expected_hits [$];

   assign pending = expected_hits.size();

   function automatic logic sp_nan(input logic [31:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
   endfunction

   function automatic real sp_to_real(input logic [31:0] x);
      logic [63:0]     d;
      logic [23:0]     m;
      int              e;
      d = {x[31], 63'd0};
      if (x[30:23] == 8'hFF) begin
         d[62:52] = 11'h7FF;
         d[51]    = (x[22:0] != 23'd0);
      end else if (x[30:0] != 31'd0) begin
         if (x[30:23] == 8'd0) begin
            m = {1'b0, x[22:0]};
            e = -126;
            while (!m[23]) begin
               m = m << 1;
               e = e - 1;
            end
         end else begin
            m = {1'b1, x[22:0]};
            e = int'(x[30:23]) - 127;
         end
         d[62:52] = 11'(e + 1023);
         d[51:29] = m[22:0];
      end
      return $bitstoreal(d);
   endfunction

   // round to nearest even, single precision
   function automatic logic [31:0] real_to_sp(input real v);
      logic [63:0] d;
      logic [63:0] m;
      logic [63:0] kept;
      logic [63:0] rest;
      logic [63:0] half;
      logic [63:0] res;
      int          e;
      int          sh;
      int          base;
      d = $realtobits(v);
      if (d[62:52] == 11'h7FF) return (d[51:0] != 52'd0) ? 32'h7FC00000 : {d[63], 31'h7F800000};
      if (d[62:52] == 11'd0) return {d[63], 31'd0};
      e = int'(d[62:52]) - 1023;
      if (e >= -126) begin
         sh   = 29;
         base = e + 126;
      end else begin
         sh   = 29 - 126 - e;
         base = 0;
      end
      if (sh > 60) return {d[63], 31'd0};
      if (base >= 254) return {d[63], 31'h7F800000};
      m    = {11'd1, d[51:0]};
      kept = m >> sh;
      rest = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rest > half || (rest == half && kept[0])) kept = kept + 64'd1;
      res = (64'(base) << 23) + kept;
      if (res >= 64'h7F800000) return {d[63], 31'h7F800000};
      return {d[63], res[30:0]};
   endfunction

   function automatic logic sp_less(input logic [31:0] a, input logic [31:0] b);
      if (sp_nan(a) || sp_nan(b)) return 1'b0;
      if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return 1'b0;
      if (a[31] != b[31]) return a[31];
      if (!a[31]) return a[30:0] < b[30:0];
      return a[30:0] > b[30:0];
   endfunction

   function automatic logic [31:0] sp_lower(input logic [31:0] x, input logic [31:0] y);
      return sp_less(y, x) ? y : x;
   endfunction

   function automatic logic [31:0] sp_upper(input logic [31:0] x, input logic [31:0] y);
      return sp_less(x, y) ? y : x;
   endfunction

   function automatic slab_result_type box_test(input logic [223:0] ray);
      slab_result_type r;
      logic [31:0]  t0 [3];
      logic [31:0]  t1 [3];
      logic [31:0]  o;
      logic [31:0]  dr;
      logic [31:0]  inv;
      logic [31:0]  d0;
      logic [31:0]  d1;
      logic [31:0]  nr;
      logic [31:0]  fr;
      logic         overlap;
      int           b;
      overlap = 1'b1;
      for (int a = 0; a < 3; a++) begin
         o  = ray[32*a +: 32];
         dr = ray[32*(a+3) +: 32];
         if (dr[30:0] == 31'd0) inv = {dr[31], 31'h7F800000};
         else inv = real_to_sp(1.0 / sp_to_real(dr));
         d0 = real_to_sp(sp_to_real(corner_lo[a]) - sp_to_real(o));
         d1 = real_to_sp(sp_to_real(corner_hi[a]) - sp_to_real(o));
         t0[a] = real_to_sp(sp_to_real(d0) * sp_to_real(inv));
         t1[a] = real_to_sp(sp_to_real(d1) * sp_to_real(inv));
      end
      for (int a = 0; a < 3; a++) begin
         b  = (a + 1) % 3;
         nr = sp_upper(sp_lower(t0[a], t1[a]), sp_lower(t0[b], t1[b]));
         fr = sp_lower(sp_upper(t0[a], t1[a]), sp_upper(t0[b], t1[b]));
         if (sp_less(fr, nr)) overlap = 1'b0;
      end
      r.box_dist = 32'h7F800000;
      for (int a = 0; a < 3; a++) begin
         if (sp_less(32'd0, t0[a])) r.box_dist = sp_lower(r.box_dist, t0[a]);
         if (sp_less(32'd0, t1[a])) r.box_dist = sp_lower(r.box_dist, t1[a]);
      end
      r.hit = overlap && !sp_less(ray[192 +: 32], r.box_dist);
      return r;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t: %s got %h expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   slab_result_type want;

   always @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            corner_lo[a] <= 32'd0;
            corner_hi[a] <= 32'd0;
         end
         expected_hits.delete();
         mismatches <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hits.size() == 0) begin
               report("unexpected item", {8'd0, rsp_tdata[39:16]}, 32'd0);
            end else begin
               want = expected_hits.pop_front();
               if (rsp_tdata[0] !== want.hit) report("hit", {31'd0, rsp_tdata[0]}, {31'd0, want.hit});
               if (rsp_tdata[32:1] !== want.box_dist)
                  report("box_distance", rsp_tdata[32:1], want.box_dist);
            end
         end
         if (req_tvalid && req_tready) expected_hits.push_back(box_test(req_tdata));
         if (csr_valid && csr_ready) begin
            if (csr_index < 3'd3) corner_lo[csr_index[1:0]] <= csr_data;
            else if (csr_index < 3'd6) corner_hi[2'(csr_index - 3'd3)] <= csr_data;
         end
      end
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench
   import rbst_pkg::*;
;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [223:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = 3'd0;
   logic [31:0]  csr_data = 32'd0;
   int           mismatches;
   int           pending;
   int           burst_left = 0;
   int           stall_mode = 0;

   localparam logic [31:0] ONE = 32'h3F800000;
   localparam logic [31:0] NEG_ONE = 32'hBF800000;
   localparam logic [31:0] FIVE = 32'h40A00000;
   localparam logic [31:0] NEG_FIVE = 32'hC0A00000;
   localparam logic [31:0] NEG_INF = 32'hFF800000;
   localparam logic [31:0] NEG_ZERO = 32'h80000000;

   always #6 clock = ~clock;

   ray_box_slab_test u_top (.*);

   ray_box_checker u_checker (.*);

   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 9) < 7);
         2: rsp_tready <= ($urandom_range(0, 9) < 2);
         default: rsp_tready <= (int'($realtime / 12.0) % 5) != 0;
      endcase
   end

   task automatic write_corner(input csr_index_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
   endtask

   task automatic set_box(input logic [31:0] lx, input logic [31:0] ly, input logic [31:0] lz,
                          input logic [31:0] hx, input logic [31:0] hy, input logic [31:0] hz);
      write_corner(CSR_BOX_MIN_X, lx);
      write_corner(CSR_BOX_MIN_Y, ly);
      write_corner(CSR_BOX_MIN_Z, lz);
      write_corner(CSR_BOX_MAX_X, hx);
      write_corner(CSR_BOX_MAX_Y, hy);
      write_corner(CSR_BOX_MAX_Z, hz);
   endtask

   task automatic send_ray(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
                           input logic [31:0] dx, input logic [31:0] dy, input logic [31:0] dz,
                           input logic [31:0] limit);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {limit, dz, dy, dx, oz, oy, ox};
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] any_float();
      logic [31:0] f;
      f = $urandom();
      case ($urandom_range(0, 9))
         0: f = {f[31], 31'd0};
         1: f = {f[31], 31'h7F800000};
         2: f = {f[31], 8'hFF, f[22:0] | 23'd1};
         3: f = {f[31], 8'd0, f[22:0]};
         4: f = {f[31], 8'hFE, f[22:0]};
         5, 6, 7: f = {f[31], 8'(124 + $urandom_range(0, 6)), f[22:0]};
         default: ;
      endcase
      return f;
   endfunction

   function automatic logic [31:0] tame_float(input int lo_e, input int hi_e);
      logic [31:0] f;
      f = $urandom();
      if ($urandom_range(0, 15) == 0) return {f[31], 31'd0};
      return {f[31], 8'(127 + $urandom_range(0, hi_e - lo_e) + lo_e), f[22:0]};
   endfunction

   task automatic random_rays(input int count);
      logic [31:0] limit;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 3))
               0: limit = 32'h7F800000;
               1: limit = any_float();
               default: limit = tame_float(-2, 4);
            endcase
            send_ray(tame_float(-3, 3), tame_float(-3, 3), tame_float(-3, 3),
                     tame_float(-4, 2), tame_float(-4, 2), tame_float(-4, 2), limit);
         end else begin
            send_ray(any_float(), any_float(), any_float(), any_float(), any_float(),
                     any_float(), any_float());
         end
      end
      drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      random_rays(20);

      set_box(NEG_ONE, NEG_ONE, NEG_ONE, ONE, ONE, ONE);
      send_ray(32'd0, 32'd0, NEG_FIVE, 32'd0, 32'd0, ONE, 32'h7F800000);
      send_ray(32'd0, 32'd0, NEG_FIVE, NEG_ZERO, 32'd0, ONE, 32'h7F800000);
      send_ray(32'd0, 32'd0, FIVE, 32'd0, 32'd0, NEG_ONE, 32'h7F800000);
      send_ray(32'd0, 32'd0, NEG_FIVE, 32'd0, 32'd0, ONE, ONE);
      send_ray(32'd0, 32'd0, NEG_FIVE, 32'd0, 32'd0, ONE, 32'h7FC00000);
      send_ray(32'd0, 32'd0, 32'd0, ONE, ONE, ONE, 32'h7F800000);
      send_ray(FIVE, FIVE, NEG_FIVE, 32'd0, 32'd0, ONE, 32'h7F800000);
      send_ray(ONE, 32'd0, NEG_FIVE, 32'd0, 32'd0, ONE, 32'h7F800000);
      send_ray(32'd0, 32'd0, NEG_FIVE, 32'd0, 32'd0, 32'd0, 32'h7F800000);
      send_ray(32'h7FC00000, 32'd0, NEG_FIVE, 32'd0, 32'd0, ONE, 32'h7F800000);
      send_ray(NEG_INF, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'h7F800000);
      send_ray(32'd0, 32'd0, NEG_FIVE, 32'h00000001, 32'h80000001, ONE, 32'd0);
      send_ray(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
               32'hFFFFFFFF, 32'hFFFFFFFF);
      send_ray(32'h7F7FFFFF, 32'hFF7FFFFF, 32'd0, 32'h00000001, 32'h7F7FFFFF, NEG_ONE,
               32'h7F7FFFFF);
      send_ray(32'd0, 32'd0, NEG_FIVE, NEG_INF, 32'h7F800000, ONE, NEG_ZERO);
      drain();
      random_rays(90);

      set_box(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
              32'hFFFFFFFF);
      random_rays(30);

      set_box(32'hFF7FFFFF, 32'hFF800000, 32'h80000001, 32'h7F7FFFFF, 32'h7F800000,
              32'h00000001);
      random_rays(50);

      set_box(tame_float(-3, 1) | 32'h80000000, tame_float(-3, 1) | 32'h80000000,
              tame_float(-3, 1) | 32'h80000000, tame_float(-3, 1) & 32'h7FFFFFFF,
              tame_float(-3, 1) & 32'h7FFFFFFF, tame_float(-3, 1) & 32'h7FFFFFFF);
      random_rays(110);

      set_box(any_float(), any_float(), any_float(), any_float(), any_float(), any_float());
      random_rays(80);

      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #(12 * 200000);
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== ray_box_slab_test.f =====
design/rbst_pkg.sv
design/ray_box_slab_test.sv
bench/ray_box_checker.sv
bench/testbench.sv
